[sv/bts_pkg.sv]
// ----------------------------------------------------------------------------
// bts_pkg: shared types and constants of the beeper tone sequencer
// Item kinds, the sequencer-to-PWM command struct and the G-major note table.
// ----------------------------------------------------------------------------
package bts_pkg;

  // item kinds carried in the input tuser
  typedef enum logic [1:0] {
    OP_CTRL_TICK  = 2'd0,
    OP_TIMER_TICK = 2'd1,
    OP_SET_NOTE   = 2'd2,
    OP_KEY_CLICK  = 2'd3
  } op_t;

  localparam int NOTE_W   = 3;
  localparam int CLICK_W  = 2;
  localparam int STEP_W   = 6;
  localparam int OUT_W    = 9;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  // notes used by the sequencer
  localparam logic [NOTE_W-1:0] CLICK_NOTE   = 3'd7;
  localparam logic [NOTE_W-1:0] PATTERN_NOTE_A = 3'd5;
  localparam logic [NOTE_W-1:0] PATTERN_NOTE_B = 3'd1;

  // alarm pattern step codes
  localparam logic [STEP_W-1:0] STEP_A_ON  = 6'h00;
  localparam logic [STEP_W-1:0] STEP_A_OFF = 6'h0F;
  localparam logic [STEP_W-1:0] STEP_B_ON  = 6'h10;
  localparam logic [STEP_W-1:0] STEP_B_OFF = 6'h1F;

  // reset values of the period and compare registers
  localparam logic [OUT_W-1:0] PERIOD_RESET  = 9'd225;
  localparam logic [OUT_W-1:0] COMPARE_RESET = 9'd112;

  // command from the sequencer to the pwm
  typedef struct packed {
    logic              load;
    logic [NOTE_W-1:0] note;
    logic              start;
    logic              stop;
  } seq_cmd_t;

  // period in 1 MHz ticks for each note index, 1e6/f - 1
  function automatic logic [OUT_W-1:0] note_period(input logic [NOTE_W-1:0] idx);
    logic [OUT_W-1:0] p;
    case (idx)
      3'd1:    p = 9'd317;  // 3136 Hz
      3'd2:    p = 9'd283;  // 3520 Hz
      3'd3:    p = 9'd252;  // 3951 Hz
      3'd4:    p = 9'd237;  // 4186 Hz
      3'd5:    p = 9'd211;  // 4698 Hz
      3'd6:    p = 9'd188;  // 5274 Hz
      3'd7:    p = 9'd167;  // 5920 Hz
      default: p = 9'd211;  // index zero plays the default note
    endcase
    return p;
  endfunction

endpackage

[sv/bts_seq.sv]
// ----------------------------------------------------------------------------
// bts_seq: tone sequencer
// Key click, continuous and alarm pattern control; issues note loads and
// start/stop commands to the pwm.
// ----------------------------------------------------------------------------
module bts_seq #(
  parameter int CLICK_TICKS  = 2,
  parameter int PATTERN_BITS = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  bts_pkg::op_t                  op,
  input  logic [bts_pkg::NOTE_W-1:0]    note,
  input  logic                          continuous_on,
  input  logic                          pattern_on,
  output bts_pkg::seq_cmd_t             cmd
);
  import bts_pkg::*;

  logic [CLICK_W-1:0]      click_left, click_left_next;
  logic [PATTERN_BITS-1:0] pattern_step, pattern_step_next;
  logic                    status, status_next;
  logic [PATTERN_BITS+STEP_W-1:0] step_ext;
  logic [STEP_W-1:0]       step_code;

  // pattern step seen through the six-bit decode window
  assign step_ext  = {{STEP_W{1'b0}}, pattern_step};
  assign step_code = step_ext[STEP_W-1:0];

  // next state and commands
  always_comb begin
    click_left_next   = click_left;
    pattern_step_next = pattern_step;
    status_next       = status;
    cmd               = '0;
    if (fire) begin
      case (op)
        OP_CTRL_TICK: begin
          if (click_left != '0) begin
            if (click_left == CLICK_W'(CLICK_TICKS)) begin
              cmd.load    = 1'b1;
              cmd.note    = CLICK_NOTE;
              status_next = 1'b1;
            end
            click_left_next = click_left - CLICK_W'(1);
          end else if (continuous_on) begin
            status_next = 1'b1;
          end else if (pattern_on) begin
            if (step_code == STEP_A_ON) begin
              cmd.load    = 1'b1;
              cmd.note    = PATTERN_NOTE_A;
              status_next = 1'b1;
            end
            if (step_code == STEP_A_OFF) begin
              status_next = 1'b0;
            end
            if (step_code == STEP_B_ON) begin
              cmd.load    = 1'b1;
              cmd.note    = PATTERN_NOTE_B;
              status_next = 1'b1;
            end
            if (step_code == STEP_B_OFF) begin
              status_next = 1'b0;
            end
            pattern_step_next = pattern_step + PATTERN_BITS'(1);
          end else begin
            status_next       = 1'b0;
            pattern_step_next = '0;
          end
          // edges of the status start and stop the pwm
          cmd.start = status_next & ~status;
          cmd.stop  = status & ~status_next;
        end
        OP_SET_NOTE: begin
          cmd.load = 1'b1;
          cmd.note = note;
        end
        OP_KEY_CLICK: begin
          click_left_next = CLICK_W'(CLICK_TICKS);
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      click_left   <= '0;
      pattern_step <= '0;
      status       <= 1'b0;
    end else begin
      click_left   <= click_left_next;
      pattern_step <= pattern_step_next;
      status       <= status_next;
    end
  end

endmodule

[sv/bts_pwm.sv]
// ----------------------------------------------------------------------------
// bts_pwm: up-counting tone pwm
// Period and compare registers loaded from the note table, and a counter
// advanced by timer ticks while running. Exposes the post-item view.
// ----------------------------------------------------------------------------
module bts_pwm #(
  parameter int PERIOD_BITS = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        tick,
  input  bts_pkg::seq_cmd_t           cmd,
  output logic                        running_next,
  output logic                        level_next,
  output logic [bts_pkg::OUT_W-1:0]   period_view,
  output logic [bts_pkg::OUT_W-1:0]   compare_view
);
  import bts_pkg::*;

  logic [PERIOD_BITS-1:0] period, period_next;
  logic [PERIOD_BITS-1:0] compare, compare_next;
  logic [PERIOD_BITS-1:0] count, count_next;
  logic                   running;
  logic [PERIOD_BITS-1:0] load_period;

  assign load_period = PERIOD_BITS'(note_period(cmd.note));

  // register updates for this item
  always_comb begin
    period_next  = period;
    compare_next = compare;
    count_next   = count;
    running_next = running;
    if (cmd.load) begin
      period_next  = load_period;
      compare_next = (load_period >> 1) + PERIOD_BITS'(1);
      count_next   = '0;
    end
    if (cmd.start) begin
      running_next = 1'b1;
    end
    if (cmd.stop) begin
      running_next = 1'b0;
    end
    // count wraps after reaching the period
    if (tick && running) begin
      if (count >= period) begin
        count_next = '0;
      end else begin
        count_next = count + PERIOD_BITS'(1);
      end
    end
  end

  // view after the item
  assign level_next   = running_next && (count_next < compare_next);
  assign period_view  = period_next[OUT_W-1:0];
  assign compare_view = compare_next[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      period  <= PERIOD_BITS'(PERIOD_RESET);
      compare <= PERIOD_BITS'(COMPARE_RESET);
      count   <= '0;
      running <= 1'b0;
    end else begin
      period  <= period_next;
      compare <= compare_next;
      count   <= count_next;
      running <= running_next;
    end
  end

endmodule

[sv/beeper_tone_sequencer.sv]
// ----------------------------------------------------------------------------
// beeper_tone_sequencer: sequenced pwm beeper
// Click, continuous and alarm-pattern tone control with a note-table pwm.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_ stream. s_tuser carries the item kind
//   (control tick, 1 MHz timer tick, set note, key click); s_tdata carries
//   the note index and the continuous and pattern requests.
//   Every input item yields exactly one result item on the m_ stream with
//   the beeper status, pwm pin level, period and compare registers as they
//   stand after the item, and the start/stop edge flags of a control tick.
//   m_tvalid rises in the cycle after acceptance. One item is accepted every
//   cycle while m_tready is high; the state update and the note table lookup
//   fit in one pass between the input handshake and the result register.
//   When the receiver stalls, the result register holds its item and
//   s_tready drops until it is taken; when it is taken, a new item is
//   accepted in that same cycle.
//   Reset clears the sequencer, stops the pwm, loads period 225 and
//   compare 112 and empties the result register.
// ----------------------------------------------------------------------------
module beeper_tone_sequencer #(
  parameter int CLICK_TICKS  = 2,
  parameter int PATTERN_BITS = 6,
  parameter int PERIOD_BITS  = 9
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // note[2:0], continuous_on[3], pattern_on[4], zeros[7:5]
  input  logic [bts_pkg::IN_DATA_W-1:0]     s_tdata,
  // op[1:0]
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // tone_enabled[0], pwm_level[1], period_now[10:2], compare_now[19:11],
  // started[20], stopped[21], zeros[23:22]
  output logic [bts_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import bts_pkg::*;

  logic             fire;
  op_t              op;
  seq_cmd_t         cmd;
  logic             running_next;
  logic             level_next;
  logic [OUT_W-1:0] period_view;
  logic [OUT_W-1:0] compare_view;
  logic             timer_tick;

  // accept while the result register is empty or being drained
  assign s_tready   = !m_tvalid || m_tready;
  assign fire       = s_tvalid && s_tready;
  assign op         = op_t'(s_tuser);
  assign timer_tick = fire && (op == OP_TIMER_TICK);

  bts_seq #(
    .CLICK_TICKS  (CLICK_TICKS),
    .PATTERN_BITS (PATTERN_BITS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .op            (op),
    .note          (s_tdata[NOTE_W-1:0]),
    .continuous_on (s_tdata[3]),
    .pattern_on    (s_tdata[4]),
    .cmd           (cmd)
  );

  bts_pwm #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_pwm (
    .clk          (clk),
    .rst          (rst),
    .tick         (timer_tick),
    .cmd          (cmd),
    .running_next (running_next),
    .level_next   (level_next),
    .period_view  (period_view),
    .compare_view (compare_view)
  );

  // result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {2'b00, cmd.stop, cmd.start, compare_view, period_view,
                  level_next, running_next};
    end
  end

endmodule
